// File: design/bba_pkg.sv
// Shared types and constants for the bitmap block allocator.
// No dependencies; every other design file imports this package.
package bba_pkg;

    localparam int NUM_BLOCKS             = 512;
    localparam int BLOCK_KB               = 2;
    localparam int MAX_BLOCKS_PER_REQUEST = 64;

    localparam int SIZE_W  = 8;
    localparam int BLK_W   = 9;
    localparam int CNT_W   = 10;
    localparam int NEED_W  = 8;
    localparam int EMIT_W  = $clog2(MAX_BLOCKS_PER_REQUEST + 1);
    localparam int WORD_W  = 32;
    localparam int BIT_W   = $clog2(WORD_W);
    localparam int ROW_CNT = NUM_BLOCKS / WORD_W;
    localparam int ROW_W   = $clog2(ROW_CNT);

    typedef enum logic [0:0] {
        CMD_ALLOC = 1'b0,
        CMD_FREE  = 1'b1
    } t_cmd;

    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_NO_SPACE  = 3'd1,
        ST_EMPTY     = 3'd2,
        ST_TOO_LARGE = 3'd3,
        ST_BAD_INDEX = 3'd4
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_CHECK,
        S_RD,
        S_LOAD,
        S_SCAN,
        S_FREE,
        S_OUT
    } t_state;

    typedef struct packed {
        logic [ROW_W-1:0]  rd_addr;
        logic              wr_en;
        logic [ROW_W-1:0]  wr_addr;
        logic [WORD_W-1:0] wr_data;
    } t_map_req;

    typedef struct packed {
        logic             found;
        logic [BIT_W-1:0] pos;
    } t_ffz;

endpackage

// File: design/bba_map_ram.sv
// Occupancy map storage: ROW_CNT words of WORD_W bits, registered read.
// Per-row valid flags make never-written rows read as all free. Uses bba_pkg.
module bba_map_ram
    import bba_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_map_req          i_req,
    output logic [WORD_W-1:0] o_rd_word
);

    logic [WORD_W-1:0]  r_mem [ROW_CNT];
    logic [ROW_CNT-1:0] r_row_valid;
    logic [WORD_W-1:0]  r_rd_raw;
    logic               r_rd_valid;

    always_ff @(posedge i_clk) begin
        if (i_req.wr_en) begin
            r_mem[i_req.wr_addr] <= i_req.wr_data;
        end
        r_rd_raw <= r_mem[i_req.rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row_valid <= '0;
            r_rd_valid  <= 1'b0;
        end else begin
            if (i_req.wr_en) begin
                r_row_valid[i_req.wr_addr] <= 1'b1;
            end
            r_rd_valid <= r_row_valid[i_req.rd_addr];
        end
    end

    assign o_rd_word = r_rd_valid ? r_rd_raw : '0;

endmodule

// File: design/bba_find_zero.sv
// Shared search unit: lowest clear bit of one map word.
// Uses bba_pkg.
module bba_find_zero
    import bba_pkg::*;
(
    input  logic [WORD_W-1:0] i_word,
    output t_ffz              o_ffz
);

    always_comb begin
        o_ffz.found = 1'b0;
        o_ffz.pos   = '0;
        for (int b = WORD_W - 1; b >= 0; b--) begin
            if (!i_word[b]) begin
                o_ffz.found = 1'b1;
                o_ffz.pos   = BIT_W'(b);
            end
        end
    end

endmodule

// File: design/bba_ctrl.sv
// Sequencer and datapath: request checks, word-by-word map scan, free count,
// result register. Uses bba_pkg; drives bba_map_ram and bba_find_zero.
module bba_ctrl
    import bba_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_s_valid,
    output logic              o_s_ready,
    input  t_cmd              i_cmd,
    input  logic [SIZE_W-1:0] i_size,
    input  logic [BLK_W-1:0]  i_idx,
    input  logic [WORD_W-1:0] i_rd_word,
    input  t_ffz              i_ffz,
    output t_map_req          o_map,
    output logic [WORD_W-1:0] o_word,
    output logic              o_m_valid,
    input  logic              i_m_ready,
    output logic [BLK_W-1:0]  o_blk,
    output logic              o_last,
    output t_status           o_status,
    output logic [CNT_W-1:0]  o_left
);

    t_state              r_state, n_state;
    t_cmd                r_cmd, n_cmd;
    logic [SIZE_W-1:0]   r_size, n_size;
    logic [BLK_W-1:0]    r_idx, n_idx;
    logic [NEED_W-1:0]   r_need, n_need;
    logic [EMIT_W-1:0]   r_cnt, n_cnt;
    logic [ROW_W-1:0]    r_addr, n_addr;
    logic [WORD_W-1:0]   r_word, n_word;
    logic [CNT_W-1:0]    r_free, n_free;
    logic [BLK_W-1:0]    r_out_blk, n_out_blk;
    logic                r_out_last, n_out_last;
    t_status             r_out_status, n_out_status;
    logic [CNT_W-1:0]    r_out_left, n_out_left;

    logic [SIZE_W:0]     w_need_sum;
    logic [NEED_W-1:0]   w_need;
    logic                w_bad_idx;
    logic                w_bit;
    logic                w_last;

    assign w_need_sum = {1'b0, r_size} + (SIZE_W + 1)'(BLOCK_KB - 1);
    assign w_need     = NEED_W'(w_need_sum / BLOCK_KB);
    assign w_bad_idx  = {1'b0, r_idx} >= CNT_W'(NUM_BLOCKS);
    assign w_bit      = r_word[r_idx[BIT_W-1:0]];
    assign w_last     = (NEED_W'(r_cnt) + NEED_W'(1)) == r_need;

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_s_valid) n_state = S_CHECK;
            end
            S_CHECK: begin
                if (r_cmd == CMD_FREE) begin
                    n_state = w_bad_idx ? S_OUT : S_RD;
                end else if (r_size == '0 ||
                             w_need > NEED_W'(MAX_BLOCKS_PER_REQUEST) ||
                             CNT_W'(w_need) > r_free) begin
                    n_state = S_OUT;
                end else begin
                    n_state = S_RD;
                end
            end
            S_RD:   n_state = S_LOAD;
            S_LOAD: n_state = (r_cmd == CMD_FREE) ? S_FREE : S_SCAN;
            S_SCAN: n_state = i_ffz.found ? S_OUT : S_RD;
            S_FREE: n_state = S_OUT;
            S_OUT: begin
                if (i_m_ready) n_state = r_out_last ? S_IDLE : S_SCAN;
            end
            default: n_state = S_IDLE;
        endcase
    end

    // datapath and outputs
    always_comb begin
        n_cmd        = r_cmd;
        n_size       = r_size;
        n_idx        = r_idx;
        n_need       = r_need;
        n_cnt        = r_cnt;
        n_addr       = r_addr;
        n_word       = r_word;
        n_free       = r_free;
        n_out_blk    = r_out_blk;
        n_out_last   = r_out_last;
        n_out_status = r_out_status;
        n_out_left   = r_out_left;
        o_map.rd_addr = r_addr;
        o_map.wr_en   = 1'b0;
        o_map.wr_addr = r_addr;
        o_map.wr_data = r_word;
        case (r_state)
            S_IDLE: begin
                n_cmd  = i_cmd;
                n_size = i_size;
                n_idx  = i_idx;
            end
            S_CHECK: begin
                n_need       = w_need;
                n_cnt        = '0;
                n_out_blk    = '0;
                n_out_last   = 1'b1;
                n_out_left   = r_free;
                n_out_status = ST_OK;
                if (r_cmd == CMD_FREE) begin
                    n_addr = r_idx[BLK_W-1:BIT_W];
                    if (w_bad_idx) begin
                        n_out_blk    = r_idx;
                        n_out_status = ST_BAD_INDEX;
                    end
                end else begin
                    n_addr = '0;
                    if (r_size == '0) begin
                        n_out_status = ST_EMPTY;
                    end else if (w_need > NEED_W'(MAX_BLOCKS_PER_REQUEST)) begin
                        n_out_status = ST_TOO_LARGE;
                    end else if (CNT_W'(w_need) > r_free) begin
                        n_out_status = ST_NO_SPACE;
                    end
                end
            end
            S_LOAD: begin
                n_word = i_rd_word;
            end
            S_SCAN: begin
                if (i_ffz.found) begin
                    n_word           = r_word;
                    n_word[i_ffz.pos] = 1'b1;
                    o_map.wr_en      = 1'b1;
                    o_map.wr_data    = n_word;
                    n_free           = r_free - CNT_W'(1);
                    n_cnt            = r_cnt + EMIT_W'(1);
                    n_out_blk        = {r_addr, i_ffz.pos};
                    n_out_last       = w_last;
                    n_out_status     = ST_OK;
                    n_out_left       = r_free - CNT_W'(1);
                end else begin
                    n_addr = r_addr + ROW_W'(1);
                end
            end
            S_FREE: begin
                n_word                    = r_word;
                n_word[r_idx[BIT_W-1:0]]  = 1'b0;
                o_map.wr_en               = 1'b1;
                o_map.wr_data             = n_word;
                n_free                    = w_bit ? r_free + CNT_W'(1) : r_free;
                n_out_blk                 = r_idx;
                n_out_last                = 1'b1;
                n_out_status              = ST_OK;
                n_out_left                = n_free;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_free  <= CNT_W'(NUM_BLOCKS);
        end else begin
            r_state <= n_state;
            r_free  <= n_free;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd        <= n_cmd;
        r_size       <= n_size;
        r_idx        <= n_idx;
        r_need       <= n_need;
        r_cnt        <= n_cnt;
        r_addr       <= n_addr;
        r_word       <= n_word;
        r_out_blk    <= n_out_blk;
        r_out_last   <= n_out_last;
        r_out_status <= n_out_status;
        r_out_left   <= n_out_left;
    end

    assign o_s_ready = (r_state == S_IDLE);
    assign o_m_valid = (r_state == S_OUT);
    assign o_word    = r_word;
    assign o_blk     = r_out_blk;
    assign o_last    = r_out_last;
    assign o_status  = r_out_status;
    assign o_left    = r_out_left;

endmodule

// File: design/bitmap_block_allocator_top.sv
// First-fit bitmap block allocator: one bit per block, lowest free blocks first.
// Uses bba_pkg, bba_map_ram, bba_find_zero and bba_ctrl.
//
// Usage:
//   Slave channel takes one command per transaction: tuser selects allocate (0)
//   or free (1); tdata carries size_kb and block_index. Master channel returns
//   results: one per allocated block (tlast on the final one), or a single
//   result for a free or for any rejected request (no space, empty, too large,
//   bad index), in which case the map is untouched.
// Sequencing:
//   One command is in flight at a time; o_s_axis_tready is high only when idle.
//   Free: accept, check, read, load, clear and write back, then the result.
//   Rejected allocate: accept, check, result.
//   Allocate: accept and check, then read, load and search for each map word
//   visited, and search and result for each block emitted, set by the single map
//   read port and the one shared find-first-zero unit.
// Reset:
//   Synchronous, active low. Free count returns to NUM_BLOCKS at once; map rows
//   carry valid flags cleared by reset, so the map reads all free immediately.
// Stall:
//   A result waits in the output register while o_m_axis_tready is low; the
//   scan pauses and no command is taken until the last result is delivered.
module bitmap_block_allocator_top
    import bba_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [23:0] i_s_axis_tdata,  // [7:0] size_kb, [16:8] block_index, rest zero
    input  logic [0:0]  i_s_axis_tuser,  // [0] command
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [23:0] o_m_axis_tdata,  // [8:0] block_number, [18:9] free_left, rest zero
    output logic        o_m_axis_tlast,  // last
    output logic [2:0]  o_m_axis_tuser   // [2:0] status
);

    t_map_req          w_map;
    logic [WORD_W-1:0] w_rd_word;
    logic [WORD_W-1:0] w_word;
    t_ffz              w_ffz;
    logic [BLK_W-1:0]  w_blk;
    t_status           w_status;
    logic [CNT_W-1:0]  w_left;

    bba_map_ram u_map (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_req     (w_map),
        .o_rd_word (w_rd_word)
    );

    // shared search unit, fed from the working word
    bba_find_zero u_ffz (
        .i_word (w_word),
        .o_ffz  (w_ffz)
    );

    bba_ctrl u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_s_valid (i_s_axis_tvalid),
        .o_s_ready (o_s_axis_tready),
        .i_cmd     (t_cmd'(i_s_axis_tuser[0])),
        .i_size    (i_s_axis_tdata[SIZE_W-1:0]),
        .i_idx     (i_s_axis_tdata[SIZE_W+BLK_W-1:SIZE_W]),
        .i_rd_word (w_rd_word),
        .i_ffz     (w_ffz),
        .o_map     (w_map),
        .o_word    (w_word),
        .o_m_valid (o_m_axis_tvalid),
        .i_m_ready (i_m_axis_tready),
        .o_blk     (w_blk),
        .o_last    (o_m_axis_tlast),
        .o_status  (w_status),
        .o_left    (w_left)
    );

    assign o_m_axis_tdata = {5'd0, w_left, w_blk};
    assign o_m_axis_tuser = w_status;

`ifndef SYNTH
    // one command at a time: never ready while a result is pending
    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_s_axis_tready && o_m_axis_tvalid))
        else $error("input ready while result pending");

    // a taken command closes the input until its results are out
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_axis_tvalid && o_s_axis_tready) |=> !o_s_axis_tready)
        else $error("input ready right after accept");

    // rejected requests produce exactly one result
    a_reject_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && o_m_axis_tuser != ST_OK) |-> o_m_axis_tlast)
        else $error("error result without tlast");

    // free count never exceeds the map size
    a_free_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |-> (o_m_axis_tdata[18:9] <= CNT_W'(NUM_BLOCKS)))
        else $error("free count out of range");
`endif

endmodule

// File: dv/bitmap_block_allocator_top_tb.sv
// Self-checking bench for bitmap_block_allocator_top: directed and random allocate/free
// commands on the stream ports, checked against a first-fit bitmap predictor.
// Depends on bba_pkg and the allocator RTL only.
module bitmap_block_allocator_top_tb;
    import bba_pkg::*;

    localparam int IDLE_LIMIT = 2000;  // cycles with no transaction on either side
    localparam int HOLD_AT    = 700;   // result count at which the sink holds off
    localparam int HOLD_LEN   = 400;   // length of that hold, in cycles
    localparam int N_RANDOM   = 254;

    // One expected result transaction
    typedef struct packed {
        logic [BLK_W-1:0] blk;
        logic             is_last;
        t_status          status;
        logic [CNT_W-1:0] left;
    } t_alloc_result;

    // First-fit allocator predictor plus the queue of results still owed
    class t_alloc_scoreboard;
        bit            used [NUM_BLOCKS];
        int            free_cnt;
        t_alloc_result want_q [$];
        int            errors;
        int            n_alloc, n_free, n_results;
        int            n_no_space, n_empty, n_too_large;

        function new();
            free_cnt = NUM_BLOCKS;
            foreach (used[i]) used[i] = 1'b0;
        endfunction

        function void push_want(int blk, bit is_last, t_status st);
            t_alloc_result r;
            r.blk     = blk[BLK_W-1:0];
            r.is_last = is_last;
            r.status  = st;
            r.left    = free_cnt[CNT_W-1:0];
            want_q.insert(want_q.size(), r);
        endfunction

        // Called once per accepted command transaction
        function void note_command(t_cmd cmd, logic [SIZE_W-1:0] size_kb,
                                   logic [BLK_W-1:0] idx);
            int need;
            int taken;
            if (cmd == CMD_ALLOC) begin
                n_alloc++;
                need = (int'(size_kb) + BLOCK_KB - 1) / BLOCK_KB;
                if (size_kb == 0) begin
                    n_empty++;
                    push_want(0, 1'b1, ST_EMPTY);
                end else if (need > MAX_BLOCKS_PER_REQUEST) begin
                    n_too_large++;
                    push_want(0, 1'b1, ST_TOO_LARGE);
                end else if (need > free_cnt) begin
                    // all or nothing: map untouched
                    n_no_space++;
                    push_want(0, 1'b1, ST_NO_SPACE);
                end else begin
                    taken = 0;
                    for (int b = 0; b < NUM_BLOCKS && taken < need; b++) begin
                        if (!used[b]) begin
                            used[b] = 1'b1;
                            free_cnt--;
                            taken++;
                            push_want(b, taken == need, ST_OK);
                        end
                    end
                end
            end else begin
                n_free++;
                if (int'(idx) >= NUM_BLOCKS) begin
                    push_want(idx, 1'b1, ST_BAD_INDEX);
                end else begin
                    // releasing an already free block is a plain ok, count unchanged
                    if (used[idx]) begin
                        used[idx] = 1'b0;
                        free_cnt++;
                    end
                    push_want(idx, 1'b1, ST_OK);
                end
            end
        endfunction

        function void mismatch(string field, logic [31:0] exp_v, logic [31:0] act_v);
            errors++;
            if (errors <= 40)
                $display("%0t: %s mismatch: expected %0d, actual %0d",
                         $time, field, exp_v, act_v);
        endfunction

        // Called once per accepted result transaction
        function void check_result(logic [BLK_W-1:0] blk, logic is_last,
                                   logic [2:0] status, logic [CNT_W-1:0] left);
            t_alloc_result exp_r;
            n_results++;
            if (want_q.size() == 0) begin
                errors++;
                if (errors <= 40)
                    $display("%0t: unexpected result: block %0d status %0d last %0d",
                             $time, blk, status, is_last);
                return;
            end
            exp_r = want_q.pop_front();
            if (blk !== exp_r.blk)         mismatch("block_number", exp_r.blk, blk);
            if (is_last !== exp_r.is_last) mismatch("last", exp_r.is_last, is_last);
            if (status !== exp_r.status)   mismatch("status", exp_r.status, status);
            if (left !== exp_r.left)       mismatch("free_left", exp_r.left, left);
        endfunction

        // Random allocated block, or any block when none is allocated
        function int pick_used();
            int cnt;
            int k;
            cnt = 0;
            foreach (used[i]) if (used[i]) cnt++;
            if (cnt == 0) return $urandom_range(0, NUM_BLOCKS - 1);
            k = $urandom_range(0, cnt - 1);
            foreach (used[i]) begin
                if (used[i]) begin
                    if (k == 0) return i;
                    k--;
                end
            end
            return 0;
        endfunction
    endclass

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_valid = 1'b0;
    logic [23:0] s_data = '0;   // [7:0] size_kb, [16:8] block_index, rest zero
    logic [0:0]  s_user = '0;   // [0] command
    logic        m_ready = 1'b0;
    logic        o_s_axis_tready;
    logic        o_m_axis_tvalid;
    logic [23:0] o_m_axis_tdata;  // [8:0] block_number, [18:9] free_left, rest zero
    logic        o_m_axis_tlast;
    logic [2:0]  o_m_axis_tuser;  // [2:0] status

    t_alloc_scoreboard sb = new();
    int idle_cycles = 0;
    int src_count = 0;

    bitmap_block_allocator_top dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (s_valid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (s_data),
        .i_s_axis_tuser  (s_user),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (m_ready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tlast  (o_m_axis_tlast),
        .o_m_axis_tuser  (o_m_axis_tuser)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Every fourth run of 32 transactions goes without gaps
    function automatic int draw_gap(int n);
        if ((n / 32) % 4 == 3) return 0;
        return $urandom_range(0, 12);
    endfunction

    // Offer one command; returns at the edge where it is accepted.
    // tvalid stays high into the next call when that call draws no gap.
    task automatic send_cmd(t_cmd cmd, logic [SIZE_W-1:0] size_kb, logic [BLK_W-1:0] idx);
        int gap;
        gap = draw_gap(src_count);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_valid <= 1'b1;
        s_data  <= {7'b0, idx, size_kb};
        s_user  <= cmd;
        do @(posedge i_clk); while (!o_s_axis_tready);
        src_count++;
    endtask

    task automatic send_alloc(int size_kb);
        send_cmd(CMD_ALLOC, size_kb[SIZE_W-1:0], BLK_W'($urandom_range(0, NUM_BLOCKS - 1)));
    endtask

    task automatic send_free(int idx);
        send_cmd(CMD_FREE, SIZE_W'($urandom_range(0, 255)), idx[BLK_W-1:0]);
    endtask

    // Command monitor: predictor advances on each accepted command
    always @(posedge i_clk) begin
        if (i_rst_n && s_valid && o_s_axis_tready)
            sb.note_command(t_cmd'(s_user), s_data[7:0], s_data[16:8]);
    end

    // Result monitor
    always @(posedge i_clk) begin
        if (i_rst_n && o_m_axis_tvalid && m_ready)
            sb.check_result(o_m_axis_tdata[8:0], o_m_axis_tlast, o_m_axis_tuser,
                            o_m_axis_tdata[18:9]);
    end

    // Result sink: random back-pressure, plus one long hold so the allocator
    // sits on a pending result and refuses new commands meanwhile
    initial begin
        int gap;
        int got;
        got = 0;
        @(posedge i_rst_n);
        forever begin
            gap = (got == HOLD_AT) ? HOLD_LEN : draw_gap(got);
            if (gap > 0) begin
                m_ready <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            m_ready <= 1'b1;
            do @(posedge i_clk); while (!o_m_axis_tvalid);
            got++;
        end
    end

    // Watchdog: too long without any transaction on either side
    always @(posedge i_clk) begin
        if (!i_rst_n || (s_valid && o_s_axis_tready) || (o_m_axis_tvalid && m_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("%0t: watchdog expired, %0d results outstanding",
                     $time, sb.want_q.size());
            $display("bitmap_block_allocator_top verification failed");
            $finish;
        end
    end

    initial begin
        int r;
        int pct;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: size extremes, rounding, holes, fill to exhaustion
        send_alloc(0);            // empty request
        send_alloc(1);            // rounds up to one block
        send_alloc(2);
        send_alloc(3);            // two blocks
        send_alloc(255);          // too large
        send_alloc(129);          // too large, just over
        send_alloc(130);
        send_free(1);
        send_free(1);             // releasing a block that is already free
        send_alloc(128);          // 64 blocks, fills the hole at 1 first
        send_free(NUM_BLOCKS - 1);
        send_free(0);
        repeat (6) send_alloc(128);
        send_alloc(128);          // no space: 62 left, 64 needed
        send_alloc(124);          // takes the last 62
        send_alloc(1);            // no space with map full
        send_alloc(0);
        send_free(256);
        send_free(170);
        send_free(341);
        send_alloc(2);            // lowest freed block comes back first

        // Random: mostly small allocations, frees of live blocks, some noise
        for (int n = 0; n < N_RANDOM; n++) begin
            r   = $urandom_range(0, 99);
            pct = (sb.free_cnt < 80) ? 60 : 30;
            if (r < pct) begin
                if ($urandom_range(0, 9) == 0)
                    send_free($urandom_range(0, NUM_BLOCKS - 1));
                else
                    send_free(sb.pick_used());
            end else begin
                r = $urandom_range(0, 99);
                if (r < 6)       send_alloc(0);
                else if (r < 12) send_alloc($urandom_range(129, 255));
                else if (r < 20) send_alloc($urandom_range(100, 128));
                else             send_alloc($urandom_range(1, 24));
            end
        end
        s_valid <= 1'b0;

        while (sb.want_q.size() != 0) @(posedge i_clk);
        repeat (200) @(posedge i_clk);   // catch any stray results

        $display("Covered %0d commands (%0d allocate, %0d free) and %0d results;",
                 src_count, sb.n_alloc, sb.n_free, sb.n_results);
        $display("rejections seen: %0d no-space, %0d empty, %0d too-large; %0d errors",
                 sb.n_no_space, sb.n_empty, sb.n_too_large, sb.errors);
        if (sb.errors == 0)
            $display("bitmap_block_allocator_top verification clean");
        else
            $display("bitmap_block_allocator_top verification failed");
        $finish;
    end

endmodule

// File: bitmap_block_allocator_top.f
design/bba_pkg.sv
design/bba_map_ram.sv
design/bba_find_zero.sv
design/bba_ctrl.sv
design/bitmap_block_allocator_top.sv
dv/bitmap_block_allocator_top_tb.sv
